### src/wrsi_pkg.sv
// Shared types and constants for the windowed RSI block.
`timescale 1ns / 1ps
package wrsi_pkg;

  localparam int IN_BITS      = 32;
  localparam int CFG_BITS     = 7;
  localparam int QUO_BITS     = 14;
  localparam int OUT_TDATA_W  = 16;
  localparam int PERIOD_RESET = 14;
  localparam int RSI_SCALE    = 10000;
  localparam int RSI_WARMUP   = 5000;
  localparam int RSI_FULL     = 10000;

  typedef struct packed {
    logic cfg_write;
    logic load_price;
    logic ram_read;
    logic evict;
    logic commit;
    logic div_setup;
    logic div_step;
    logic load_out;
  } wrsi_cmd_t;

  typedef struct packed {
    logic div_bypass;
  } wrsi_status_t;

endpackage

### src/wrsi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wrsi_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/wrsi_ctrl.sv
// Sequencing state machine for the windowed RSI block.
`timescale 1ns / 1ps
module wrsi_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  wrsi_pkg::wrsi_status_t status,
  output wrsi_pkg::wrsi_cmd_t    cmd
);
  import wrsi_pkg::*;

  localparam int CNT_W = $clog2(QUO_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVICT,
    S_COMMIT,
    S_SETUP,
    S_DIVIDE,
    S_DONE
  } state_t;

  state_t           state_r;
  logic             in_ready_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] cnt_r;

  always_comb begin
    in_tready = in_ready_r & ~cfg_valid;
    cfg_ready = in_ready_r;
    out_tvalid = out_valid_r;
    cmd = '0;
    cmd.cfg_write = cfg_valid & in_ready_r;
    cmd.load_price = in_tvalid & in_tready;
    case (state_r)
      S_READ:   cmd.ram_read = 1'b1;
      S_EVICT:  cmd.evict = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_SETUP:  cmd.div_setup = 1'b1;
      S_DIVIDE: cmd.div_step = 1'b1;
      S_DONE:   cmd.load_out = ~out_valid_r | out_tready;
      default:  cmd.ram_read = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      in_ready_r <= 1'b1;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.load_price) begin
            state_r <= S_READ;
            in_ready_r <= 1'b0;
          end
        end
        S_READ:   state_r <= S_EVICT;
        S_EVICT:  state_r <= S_COMMIT;
        S_COMMIT: state_r <= S_SETUP;
        S_SETUP: begin
          cnt_r <= '0;
          state_r <= status.div_bypass ? S_DONE : S_DIVIDE;
        end
        S_DIVIDE: begin
          if (cnt_r == CNT_W'(QUO_BITS - 1)) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_DONE: begin
          if (cmd.load_out) begin
            state_r <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### src/wrsi_datapath.sv
// Window history, running sums and restoring divider for the RSI block.
`timescale 1ns / 1ps
module wrsi_datapath #(
  parameter int MAX_PERIOD = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wrsi_pkg::wrsi_cmd_t               cmd,
  output wrsi_pkg::wrsi_status_t            status,
  input  logic [wrsi_pkg::IN_BITS-1:0]      in_tdata,
  input  logic [wrsi_pkg::CFG_BITS-1:0]     cfg_data,
  output logic [wrsi_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser
);
  import wrsi_pkg::*;

  localparam int PW    = PRICE_BITS;
  localparam int CW    = PRICE_BITS + 1;
  localparam int SW    = PRICE_BITS + $clog2(MAX_PERIOD + 1);
  localparam int PERW  = $clog2(MAX_PERIOD + 1);
  localparam int SEENW = $clog2(MAX_PERIOD + 2);
  localparam int AW    = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int NW    = SW + QUO_BITS;
  localparam int KW    = ((PERW > SEENW) ? PERW : SEENW) + 1;
  localparam int RESET_PERIOD = (PERIOD_RESET > MAX_PERIOD) ? MAX_PERIOD : PERIOD_RESET;

  logic [PERW-1:0]     period_r;
  logic [PW-1:0]       price_r;
  logic [PW-1:0]       prev_r;
  logic signed [CW-1:0] chg_r;
  logic [AW-1:0]       ptr_r;
  logic [SEENW-1:0]    seen_r;
  logic [SW-1:0]       gain_r;
  logic [SW-1:0]       loss_r;
  logic [NW-1:0]       num_r;
  logic [NW-1:0]       den_r;
  logic [QUO_BITS-1:0] quo_r;
  logic [QUO_BITS-1:0] rsi_r;
  logic                rdy_r;

  logic [IN_BITS+PW-1:0] price_ext;
  logic [CW-1:0]       ev;
  logic [CW-1:0]       ev_neg;
  logic [CW-1:0]       chg_neg;
  logic                ev_pos;
  logic                chg_pos;
  logic                full;
  logic                ptr_wrap;
  logic [SW-1:0]       total;
  logic                ram_we;

  assign price_ext = {PW'(0), in_tdata};
  assign ev_neg    = -ev;
  assign chg_neg   = -chg_r;
  assign ev_pos    = ~ev[CW-1] & (ev != '0);
  assign chg_pos   = ~chg_r[CW-1] & (chg_r != '0);
  assign full      = KW'(seen_r) >= (KW'(period_r) + KW'(1));
  assign ptr_wrap  = (KW'(ptr_r) + KW'(1)) == KW'(period_r);
  assign total     = gain_r + loss_r;
  assign ram_we    = cmd.commit & (seen_r != '0);

  assign status.div_bypass = ~full | (loss_r == '0);
  assign out_tdata = {(OUT_TDATA_W - QUO_BITS)'(0), rsi_r};
  assign out_tuser = rdy_r;

  wrsi_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_PERIOD)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (chg_r),
    .re    (cmd.ram_read),
    .raddr (ptr_r),
    .rdata (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERW'(RESET_PERIOD);
      prev_r <= '0;
      ptr_r <= '0;
      seen_r <= '0;
      gain_r <= '0;
      loss_r <= '0;
    end else if (cmd.cfg_write) begin
      if (cfg_data == '0) begin
        period_r <= PERW'(1);
      end else if (int'(cfg_data) > MAX_PERIOD) begin
        period_r <= PERW'(MAX_PERIOD);
      end else begin
        period_r <= PERW'(cfg_data);
      end
      prev_r <= '0;
      ptr_r <= '0;
      seen_r <= '0;
      gain_r <= '0;
      loss_r <= '0;
    end else if (cmd.evict) begin
      if (seen_r != '0 && full) begin
        if (ev_pos) begin
          gain_r <= gain_r - SW'(ev[PW-1:0]);
        end else begin
          loss_r <= loss_r - SW'(ev_neg[PW-1:0]);
        end
      end
    end else if (cmd.commit) begin
      prev_r <= price_r;
      if (seen_r == '0) begin
        seen_r <= SEENW'(1);
      end else begin
        if (!full) begin
          seen_r <= seen_r + SEENW'(1);
        end
        if (chg_pos) begin
          gain_r <= gain_r + SW'(chg_r[PW-1:0]);
        end else begin
          loss_r <= loss_r + SW'(chg_neg[PW-1:0]);
        end
        ptr_r <= ptr_wrap ? '0 : ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_price) begin
      price_r <= price_ext[PW-1:0];
    end
    if (cmd.ram_read) begin
      chg_r <= {1'b0, price_r} - {1'b0, prev_r};
    end
    if (cmd.div_setup) begin
      num_r <= NW'(gain_r) * NW'(RSI_SCALE);
      den_r <= NW'(total) << (QUO_BITS - 1);
      quo_r <= '0;
    end else if (cmd.div_step) begin
      if (num_r >= den_r) begin
        num_r <= num_r - den_r;
        quo_r <= {quo_r[QUO_BITS-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[QUO_BITS-2:0], 1'b0};
      end
      den_r <= den_r >> 1;
    end
    if (cmd.load_out) begin
      rdy_r <= full;
      if (!full) begin
        rsi_r <= QUO_BITS'(RSI_WARMUP);
      end else if (loss_r == '0) begin
        rsi_r <= QUO_BITS'(RSI_FULL);
      end else begin
        rsi_r <= quo_r;
      end
    end
  end

endmodule

### src/window_rsi_indicator_unit.sv
// Top level of the windowed RSI block: controller plus datapath.
//
//  channel | direction | handshake           | payload
//  in_     | in        | in_tvalid/in_tready | in_tdata[31:0] close_price
//  out_    | out       | out_tvalid/out_tready | out_tdata[13:0] rsi_hundredths,
//          |           |                     | out_tuser ready_res
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_data[6:0] rsi_period
//
// An item passes through the restoring divider only when the window is
// full and has losses; otherwise the divider is bypassed.
// Each item takes one ring RAM read and at most one write.
// Reset is synchronous, active low; there is no clearing pass.
// A result waits in the output register while the next item is worked on;
// the next result holds in the last step, input closed, until out_tready frees it.
`timescale 1ns / 1ps
module window_rsi_indicator_unit #(
  parameter int MAX_PERIOD = 64,
  parameter int PRICE_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wrsi_pkg::IN_BITS-1:0]     in_tdata,   // [31:0] close_price
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wrsi_pkg::OUT_TDATA_W-1:0] out_tdata,  // [13:0] rsi_hundredths
  output logic                             out_tuser,  // [0] ready_res
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wrsi_pkg::CFG_BITS-1:0]    cfg_data
);
  import wrsi_pkg::*;

  wrsi_cmd_t    cmd;
  wrsi_status_t status;

  wrsi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  wrsi_datapath #(
    .MAX_PERIOD (MAX_PERIOD),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

### verif/tb_window_rsi_indicator_unit.sv
// Self-checking testbench for the windowed RSI unit, predicted per close and checked per transfer.
`timescale 1ns / 1ps
module tb_window_rsi_indicator_unit;
  import wrsi_pkg::*;

  localparam int MAX_PERIOD = 64;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_WAIT = 30;
  localparam int HOLD_OFF   = 400;
  localparam int PRINT_CAP  = 30;

  typedef struct packed {
    logic [QUO_BITS-1:0] rsi;
    logic                ready;
  } rsi_result_t;

  typedef enum int {WALK_NOISE, WALK_RISE, WALK_FALL, WALK_FLAT, WALK_JUMP} walk_kind_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_BITS-1:0]     in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_BITS-1:0]    cfg_data   = '0;

  // predictor state
  int                 win_period;
  logic [IN_BITS-1:0] last_close;
  longint             change_hist [MAX_PERIOD];
  int                 hist_ptr;
  int                 closes_count;
  longint unsigned    gain_total;
  longint unsigned    loss_total;

  rsi_result_t        rsi_expected_q [$];
  logic [IN_BITS-1:0] walk_close = '0;
  bit                 idle_on    = 1'b1;
  int                 hold_left  = 0;
  int                 closes_sent = 0;
  int                 results_seen = 0;
  int                 period_writes = 0;
  int                 mismatches = 0;
  int                 stuck_cycles = 0;

  window_rsi_indicator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function void restart_window();
    last_close   = '0;
    hist_ptr     = 0;
    closes_count = 0;
    gain_total   = 0;
    loss_total   = 0;
    foreach (change_hist[i]) change_hist[i] = 0;
  endfunction

  function void set_period(input logic [CFG_BITS-1:0] value);
    win_period = int'(value);
    if (win_period < 1) win_period = 1;
    if (win_period > MAX_PERIOD) win_period = MAX_PERIOD;
    restart_window();
  endfunction

  function void account_change(input longint delta, input bit add);
    if (delta > 0) begin
      gain_total = add ? gain_total + delta : gain_total - delta;
    end else begin
      loss_total = add ? loss_total - delta : loss_total + delta;
    end
  endfunction

  function void predict_rsi(input logic [IN_BITS-1:0] price);
    longint      delta;
    int          slot;
    rsi_result_t res;
    if (closes_count == 0) begin
      closes_count = 1;
    end else begin
      delta = $signed({32'd0, price}) - $signed({32'd0, last_close});
      slot  = hist_ptr % win_period;
      if (closes_count >= win_period + 1) begin
        account_change(change_hist[slot], 1'b0);
      end else begin
        closes_count++;
      end
      change_hist[slot] = delta;
      account_change(delta, 1'b1);
      hist_ptr = (slot + 1) % win_period;
    end
    last_close = price;
    res.ready  = (closes_count >= win_period + 1);
    res.rsi    = QUO_BITS'(RSI_WARMUP);
    if (res.ready) begin
      if (loss_total == 0) begin
        res.rsi = QUO_BITS'(RSI_FULL);
      end else begin
        res.rsi = QUO_BITS'((gain_total * RSI_SCALE) / (gain_total + loss_total));
      end
    end
    rsi_expected_q.insert(rsi_expected_q.size(), res);
  endfunction

  function logic [IN_BITS-1:0] next_close(input walk_kind_t kind);
    case (kind)
      WALK_NOISE: walk_close = walk_close + $urandom_range(0, 2000) - 1000;
      WALK_RISE:  walk_close = walk_close + $urandom_range(0, 60);
      WALK_FALL:  walk_close = walk_close - $urandom_range(0, 60);
      WALK_JUMP:  walk_close = $urandom();
      default:    walk_close = walk_close;
    endcase
    return walk_close;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_close(input logic [IN_BITS-1:0] price);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= price;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_rsi(price);
    closes_sent++;
    @(negedge clk);
  endtask

  task automatic write_period(input logic [CFG_BITS-1:0] value);
    in_tvalid <= 1'b0;
    while (rsi_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_period(value);
    period_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_walk(input walk_kind_t kind, input int count);
    repeat (count) send_close(next_close(kind));
  endtask

  task automatic run_mixed(input int count);
    int seg;
    while (count > 0) begin
      seg = $urandom_range(1, 12);
      if (seg > count) seg = count;
      run_walk(walk_kind_t'($urandom_range(0, 4)), seg);
      count -= seg;
    end
  endtask

  // warm-up at the reset period, single-change window, short window with flat tail
  task automatic test_directed_extremes();
    send_close(32'h0000_0000);
    send_close(32'hFFFF_FFFF);
    send_close(32'h0000_0000);
    write_period(7'd0);
    send_close(32'hFFFF_FFFF);
    send_close(32'h0000_0000);
    send_close(32'hFFFF_FFFF);
    send_close(32'hFFFF_FFFF);
    send_close(32'h0000_0001);
    send_close(32'h0000_0000);
    write_period(7'd2);
    send_close(32'h5555_5555);
    send_close(32'hAAAA_AAAA);
    send_close(32'd10);
    send_close(32'd20);
    send_close(32'd30);
    send_close(32'd25);
    send_close(32'd25);
    send_close(32'd25);
    walk_close = 32'd25;
  endtask

  // widest window with the largest sums, then the smallest period
  task automatic test_period_limits();
    write_period(7'd127);
    run_walk(WALK_JUMP, 80);
    write_period(7'd64);
    run_walk(WALK_RISE, 70);
    write_period(7'd1);
    run_walk(WALK_JUMP, 10);
  endtask

  task automatic test_random_walks();
    logic [CFG_BITS-1:0] period;
    while (closes_sent < 560) begin
      case ($urandom_range(0, 9))
        0:       period = 7'd0;
        1:       period = 7'd127;
        2:       period = 7'd65;
        3:       period = CFG_BITS'($urandom_range(17, 64));
        default: period = CFG_BITS'($urandom_range(1, 16));
      endcase
      write_period(period);
      idle_on = ($urandom_range(0, 3) != 0);
      run_mixed(win_period + 1 + $urandom_range(10, 50));
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_hold_off();
    idle_on   = 1'b0;
    hold_left = HOLD_OFF;
    run_mixed(12);
    idle_on   = 1'b1;
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    write_period(7'd5);
    run_mixed(60);
  endtask

  // receiver: random stall bursts, plus a long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stuck_cycles < 0) begin
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(0, 3)) begin
          out_tready <= 1'b0;
          @(negedge clk);
        end
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_rsi
    rsi_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (rsi_expected_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", out_tdata));
      end else begin
        want = rsi_expected_q.pop_front();
        if (out_tdata[QUO_BITS-1:0] !== want.rsi)
          report_mismatch($sformatf("rsi_hundredths %0d, expected %0d",
                                    out_tdata[QUO_BITS-1:0], want.rsi));
        if (out_tuser !== want.ready)
          report_mismatch($sformatf("ready_res %b, expected %b", out_tuser, want.ready));
        if (out_tdata[OUT_TDATA_W-1:QUO_BITS] !== '0)
          report_mismatch($sformatf("tdata padding %b not zero",
                                    out_tdata[OUT_TDATA_W-1:QUO_BITS]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 stuck_cycles, rsi_expected_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    win_period = PERIOD_RESET;
    restart_window();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_extremes();
    test_period_limits();
    test_random_walks();
    test_output_hold_off();
    test_no_idle();
    in_tvalid <= 1'b0;
    while (rsi_expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("covered %0d closes and %0d results over %0d period writes,",
             closes_sent, results_seen, period_writes);
    $display("including clamped periods, full-range prices and a %0d-cycle output hold",
             HOLD_OFF);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
